>>> rtl/indexed_min_heap_degree_queue_unit_macros.svh
// ----------------------------------------------------------------------------
// Indexed min-heap degree queue: assertion macros
// Shared property wrappers for the checker of the queue unit.
// ----------------------------------------------------------------------------
`ifndef INDEXED_MIN_HEAP_DEGREE_QUEUE_UNIT_MACROS_SVH
`define INDEXED_MIN_HEAP_DEGREE_QUEUE_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IMDQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("imdq: same-cycle property failed");

// Consequent must hold in the cycle after the antecedent.
`define IMDQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("imdq: next-cycle property failed");

`endif

>>> rtl/imdq_pkg.sv
// ----------------------------------------------------------------------------
// Indexed min-heap degree queue: package
// Item types, operation and status codes, and controller/datapath interface.
// ----------------------------------------------------------------------------
package imdq_pkg;

   localparam int VERTEX_W = 10;
   localparam int DEGREE_W = 10;
   localparam int COUNT_W  = 11;

   // Operation codes carried by an input item.
   typedef enum logic [1:0] {
      FUNC_LOAD      = 2'd0,
      FUNC_BUILD     = 2'd1,
      FUNC_EXTRACT   = 2'd2,
      FUNC_DECREMENT = 2'd3
   } func_type;

   // Completion status returned with every result item.
   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_EMPTY     = 3'd1,
      STATUS_FULL      = 3'd2,
      STATUS_IGNORED   = 3'd3,
      STATUS_SATURATED = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]          func;
      logic [VERTEX_W-1:0] vertex;
      logic [DEGREE_W-1:0] degree;
   } req_type;

   typedef struct packed {
      logic [VERTEX_W-1:0] min_vertex;
      logic [DEGREE_W-1:0] min_degree;
      logic [COUNT_W-1:0]  entry_count;
      logic [2:0]          status;
   } rsp_type;

   // One heap slot.
   typedef struct packed {
      logic [VERTEX_W-1:0] vertex;
      logic [DEGREE_W-1:0] degree;
   } slot_type;

   // Controller states.
   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_EXT_SAVE,
      ST_EXT_TAKE,
      ST_BLD_TAKE,
      ST_BLD_NEXT,
      ST_SD_LEFT,
      ST_SD_RIGHT,
      ST_SD_STEP,
      ST_EXT_PRUNE,
      ST_DEC_MAP,
      ST_DEC_SLOT,
      ST_SU_CHECK,
      ST_SU_STEP,
      ST_ROOT,
      ST_FINISH
   } state_type;

   // Datapath commands, one per cycle.
   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR,
      OP_CAPTURE,
      OP_FAIL,
      OP_LOAD,
      OP_BUILD_INIT,
      OP_EXT_READ_ROOT,
      OP_EXT_SAVE,
      OP_TAKE,
      OP_BUILD_DEC,
      OP_SD_READ_LEFT,
      OP_SD_LEFT,
      OP_SD_STEP,
      OP_PLACE,
      OP_PRUNE,
      OP_DEC_READ_MAP,
      OP_DEC_READ_SLOT,
      OP_DEC_TAKE,
      OP_SU_READ_PARENT,
      OP_SU_STEP,
      OP_READ_ROOT,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type     op;
      status_type code;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     clear_done;
      logic     vertex_bad;
      logic     full;
      logic     empty;
      logic     single;
      logic     left_ok;
      logic     sd_move;
      logic     hole_zero;
      logic     k_zero;
      logic     map_bad;
      logic     slot_bad;
      logic     degree_zero;
      logic     su_move;
   } flags_type;

endpackage

>>> rtl/indexed_min_heap_degree_queue_unit.sv
// ----------------------------------------------------------------------------
// Indexed min-heap degree queue unit
// Binary min-heap of (vertex, degree) entries with a vertex position map.
// ----------------------------------------------------------------------------
// Usage: each req item carries an operation (load, build, extract minimum,
// decrement degree), a vertex and a degree; each item yields exactly one rsp
// item with the extracted or current root entry, the entry count and a status.
// req_stall is low only while the unit is idle; one item is worked at a time.
// Loads and items refused at dispatch, by the map, by the slot check or at
// degree zero go straight to the root read; extract walks the hole down
// from the root, decrement climbs from the vertex's slot and build walks
// each internal node down in turn. The unit returns to idle as the result
// is loaded. The slot memory has one read port, so a sift-down step reads
// both children one after the other before it moves the hole.
// The result sits in an output register, so the next item is accepted while
// a finished result is still stalled; a further result waits in its last
// state until that register is free. Reset empties the heap and then marks
// every map entry pruned, one per cycle, stalling req.
// ----------------------------------------------------------------------------
module indexed_min_heap_degree_queue_unit #(
   parameter int MAX_VERTICES = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  imdq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output imdq_pkg::rsp_type rsp_data
);

   imdq_pkg::cmd_type   cmd;
   imdq_pkg::flags_type flags;

   // Sequencer.
   imdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .flags     (flags),
      .cmd       (cmd)
   );

   // Memories and working registers.
   imdq_datapath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .flags    (flags),
      .rsp_data (rsp_data)
   );

endmodule

>>> rtl/imdq_datapath.sv
// ----------------------------------------------------------------------------
// Indexed min-heap degree queue: datapath
// Heap slot memory, position map memory, hole-based sift registers and the
// result register, driven by one command per cycle from the controller.
// ----------------------------------------------------------------------------
module imdq_datapath #(
   parameter int MAX_VERTICES = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  imdq_pkg::cmd_type  cmd,
   input  imdq_pkg::req_type  req_data,
   output imdq_pkg::flags_type flags,
   output imdq_pkg::rsp_type  rsp_data
);

   localparam int IW = $clog2(MAX_VERTICES);
   localparam int SW = $clog2(MAX_VERTICES + 1);
   localparam int CW = IW + 2;

   // Map entry index from a vertex number (vertex is known to be in range).
   function automatic logic [IW-1:0] map_addr(input logic [imdq_pkg::VERTEX_W-1:0] v);
      logic [IW+imdq_pkg::VERTEX_W-1:0] wide;
      wide = (IW + imdq_pkg::VERTEX_W)'(v);
      return wide[IW-1:0];
   endfunction

   // Memories.
   imdq_pkg::slot_type slot_mem [MAX_VERTICES];
   logic [IW:0]        map_mem  [MAX_VERTICES];

   // Registers.
   imdq_pkg::req_type  req_ff, req_in;
   logic [SW-1:0]      size_ff, size_in;
   logic [IW-1:0]      clear_ff, clear_in;
   logic [IW-1:0]      hole_ff, hole_in;
   logic [IW-1:0]      k_ff, k_in;
   imdq_pkg::slot_type mov_ff, mov_in;
   imdq_pkg::slot_type best_ff, best_in;
   logic [IW-1:0]      best_idx_ff, best_idx_in;
   logic               take_ff, take_in;
   imdq_pkg::slot_type out_ff, out_in;
   logic               have_ff, have_in;
   imdq_pkg::status_type status_ff, status_in;
   imdq_pkg::rsp_type  rsp_ff, rsp_in;
   imdq_pkg::slot_type rd_ff;
   logic [IW:0]        rdm_ff;

   // Memory port controls.
   logic               slot_rd_en;
   logic [IW-1:0]      slot_rd_addr;
   logic               slot_we;
   logic [IW-1:0]      slot_waddr;
   imdq_pkg::slot_type slot_wdata;
   logic               map_rd_en;
   logic               map_we;
   logic [IW-1:0]      map_waddr;
   logic [IW:0]        map_wdata;

   // Derived indices and comparisons.
   localparam int DEGREE_CMP_W = imdq_pkg::DEGREE_W;
   logic [CW-1:0]      left_idx;
   logic [CW-1:0]      right_idx;
   logic               right_ok;
   logic [IW-1:0]      parent_idx;
   logic [IW-1:0]      k_init;
   logic [DEGREE_CMP_W-1:0] cmp_degree;
   logic               right_win;
   imdq_pkg::slot_type chosen;
   logic [IW-1:0]      chosen_idx;

   assign left_idx   = {1'b0, hole_ff, 1'b1};
   assign right_idx  = CW'(left_idx + CW'(1));
   assign right_ok   = right_idx < CW'(size_ff);
   assign parent_idx = IW'((hole_ff - IW'(1)) >> 1);
   assign k_init     = IW'((size_ff - SW'(2)) >> 1);
   assign cmp_degree = take_ff ? best_ff.degree : mov_ff.degree;
   assign right_win  = right_ok && (rd_ff.degree < cmp_degree);
   assign chosen     = right_win ? rd_ff : best_ff;
   assign chosen_idx = right_win ? right_idx[IW-1:0] : best_idx_ff;

   // Status towards the controller.
   always_comb begin
      flags.func        = imdq_pkg::func_type'(req_ff.func);
      flags.clear_done  = clear_ff == IW'(MAX_VERTICES - 1);
      flags.vertex_bad  = 32'(req_ff.vertex) >= 32'(MAX_VERTICES);
      flags.full        = size_ff >= SW'(MAX_VERTICES);
      flags.empty       = size_ff == SW'(0);
      flags.single      = size_ff == SW'(1);
      flags.left_ok     = left_idx < CW'(size_ff);
      flags.sd_move     = take_ff || right_win;
      flags.hole_zero   = hole_ff == IW'(0);
      flags.k_zero      = k_ff == IW'(0);
      flags.map_bad     = rdm_ff[IW] || (CW'(rdm_ff[IW-1:0]) >= CW'(size_ff));
      flags.slot_bad    = rd_ff.vertex != req_ff.vertex;
      flags.degree_zero = rd_ff.degree == imdq_pkg::DEGREE_W'(0);
      flags.su_move     = rd_ff.degree > mov_ff.degree;
   end

   // Command decode: next register values and memory accesses.
   always_comb begin
      req_in       = req_ff;
      size_in      = size_ff;
      clear_in     = clear_ff;
      hole_in      = hole_ff;
      k_in         = k_ff;
      mov_in       = mov_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      take_in      = take_ff;
      out_in       = out_ff;
      have_in      = have_ff;
      status_in    = status_ff;
      rsp_in       = rsp_ff;
      slot_rd_en   = 1'b0;
      slot_rd_addr = IW'(0);
      slot_we      = 1'b0;
      slot_waddr   = hole_ff;
      slot_wdata   = mov_ff;
      map_rd_en    = 1'b0;
      map_we       = 1'b0;
      map_waddr    = map_addr(mov_ff.vertex);
      map_wdata    = {1'b0, hole_ff};
      unique case (cmd.op)
         imdq_pkg::OP_NONE: begin
         end
         imdq_pkg::OP_CLEAR: begin
            // Marks one map entry pruned per cycle after reset.
            map_we    = 1'b1;
            map_waddr = clear_ff;
            map_wdata = {1'b1, IW'(0)};
            clear_in  = IW'(clear_ff + IW'(1));
         end
         imdq_pkg::OP_CAPTURE: begin
            req_in    = req_data;
            have_in   = 1'b0;
            status_in = imdq_pkg::STATUS_OK;
         end
         imdq_pkg::OP_FAIL: begin
            status_in = cmd.code;
         end
         imdq_pkg::OP_LOAD: begin
            slot_we    = 1'b1;
            slot_waddr = IW'(size_ff);
            slot_wdata = {req_ff.vertex, req_ff.degree};
            map_we     = 1'b1;
            map_waddr  = map_addr(req_ff.vertex);
            map_wdata  = {1'b0, IW'(size_ff)};
            size_in    = SW'(size_ff + SW'(1));
         end
         imdq_pkg::OP_BUILD_INIT: begin
            k_in         = k_init;
            hole_in      = k_init;
            slot_rd_en   = 1'b1;
            slot_rd_addr = k_init;
         end
         imdq_pkg::OP_EXT_READ_ROOT: begin
            slot_rd_en   = 1'b1;
            slot_rd_addr = IW'(0);
         end
         imdq_pkg::OP_EXT_SAVE: begin
            out_in       = rd_ff;
            have_in      = 1'b1;
            slot_rd_en   = 1'b1;
            slot_rd_addr = IW'(size_ff - SW'(1));
            size_in      = SW'(size_ff - SW'(1));
            hole_in      = IW'(0);
         end
         imdq_pkg::OP_TAKE: begin
            mov_in = rd_ff;
         end
         imdq_pkg::OP_BUILD_DEC: begin
            k_in         = IW'(k_ff - IW'(1));
            hole_in      = IW'(k_ff - IW'(1));
            slot_rd_en   = 1'b1;
            slot_rd_addr = IW'(k_ff - IW'(1));
         end
         imdq_pkg::OP_SD_READ_LEFT: begin
            slot_rd_en   = 1'b1;
            slot_rd_addr = left_idx[IW-1:0];
         end
         imdq_pkg::OP_SD_LEFT: begin
            best_in      = rd_ff;
            best_idx_in  = left_idx[IW-1:0];
            take_in      = rd_ff.degree < mov_ff.degree;
            slot_rd_en   = right_ok;
            slot_rd_addr = right_idx[IW-1:0];
         end
         imdq_pkg::OP_SD_STEP: begin
            slot_we    = 1'b1;
            slot_wdata = chosen;
            map_we     = 1'b1;
            map_waddr  = map_addr(chosen.vertex);
            hole_in    = chosen_idx;
         end
         imdq_pkg::OP_PLACE: begin
            slot_we = 1'b1;
            map_we  = 1'b1;
         end
         imdq_pkg::OP_PRUNE: begin
            map_we    = 1'b1;
            map_waddr = map_addr(out_ff.vertex);
            map_wdata = {1'b1, IW'(0)};
         end
         imdq_pkg::OP_DEC_READ_MAP: begin
            map_rd_en = 1'b1;
         end
         imdq_pkg::OP_DEC_READ_SLOT: begin
            slot_rd_en   = 1'b1;
            slot_rd_addr = rdm_ff[IW-1:0];
            hole_in      = rdm_ff[IW-1:0];
         end
         imdq_pkg::OP_DEC_TAKE: begin
            mov_in.vertex = req_ff.vertex;
            mov_in.degree = imdq_pkg::DEGREE_W'(rd_ff.degree - imdq_pkg::DEGREE_W'(1));
         end
         imdq_pkg::OP_SU_READ_PARENT: begin
            slot_rd_en   = 1'b1;
            slot_rd_addr = parent_idx;
         end
         imdq_pkg::OP_SU_STEP: begin
            slot_we    = 1'b1;
            slot_wdata = rd_ff;
            map_we     = 1'b1;
            map_waddr  = map_addr(rd_ff.vertex);
            hole_in    = parent_idx;
         end
         imdq_pkg::OP_READ_ROOT: begin
            slot_rd_en   = 1'b1;
            slot_rd_addr = IW'(0);
         end
         imdq_pkg::OP_FINISH: begin
            if (have_ff) begin
               rsp_in.min_vertex = out_ff.vertex;
               rsp_in.min_degree = out_ff.degree;
            end else if (size_ff == SW'(0)) begin
               rsp_in.min_vertex = imdq_pkg::VERTEX_W'(0);
               rsp_in.min_degree = imdq_pkg::DEGREE_W'(0);
            end else begin
               rsp_in.min_vertex = rd_ff.vertex;
               rsp_in.min_degree = rd_ff.degree;
            end
            rsp_in.entry_count = imdq_pkg::COUNT_W'(size_ff);
            rsp_in.status      = status_ff;
         end
         default: begin
         end
      endcase
   end

   // Heap size and the map clearing counter are the only reset registers here.
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= SW'(0);
         clear_ff <= IW'(0);
      end else begin
         size_ff  <= size_in;
         clear_ff <= clear_in;
      end
   end

   // Working and result registers.
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      hole_ff     <= hole_in;
      k_ff        <= k_in;
      mov_ff      <= mov_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      take_ff     <= take_in;
      out_ff      <= out_in;
      have_ff     <= have_in;
      status_ff   <= status_in;
      rsp_ff      <= rsp_in;
   end

   // Slot memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      if (slot_rd_en) begin
         rd_ff <= slot_mem[slot_rd_addr];
      end
   end

   // Position map memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= map_wdata;
      end
      if (map_rd_en) begin
         rdm_ff <= map_mem[map_addr(req_ff.vertex)];
      end
   end

   assign rsp_data = rsp_ff;

endmodule

>>> rtl/imdq_ctrl.sv
// ----------------------------------------------------------------------------
// Indexed min-heap degree queue: controller
// Sequences load, build, extract and decrement through the datapath and
// owns both channel handshakes.
// ----------------------------------------------------------------------------
module imdq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  imdq_pkg::flags_type flags,
   output imdq_pkg::cmd_type   cmd
);

   imdq_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;
   logic                sd_exit_extract;

   assign out_free        = !rsp_valid_ff || !rsp_stall;
   assign sd_exit_extract = flags.func == imdq_pkg::FUNC_EXTRACT;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         imdq_pkg::ST_CLEAR: begin
            if (flags.clear_done) begin
               state_in = imdq_pkg::ST_IDLE;
            end
         end
         imdq_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = imdq_pkg::ST_DISPATCH;
            end
         end
         imdq_pkg::ST_DISPATCH: begin
            unique case (flags.func)
               imdq_pkg::FUNC_LOAD: begin
                  state_in = imdq_pkg::ST_ROOT;
               end
               imdq_pkg::FUNC_BUILD: begin
                  if (flags.empty || flags.single) begin
                     state_in = imdq_pkg::ST_ROOT;
                  end else begin
                     state_in = imdq_pkg::ST_BLD_TAKE;
                  end
               end
               imdq_pkg::FUNC_EXTRACT: begin
                  if (flags.empty) begin
                     state_in = imdq_pkg::ST_ROOT;
                  end else begin
                     state_in = imdq_pkg::ST_EXT_SAVE;
                  end
               end
               imdq_pkg::FUNC_DECREMENT: begin
                  if (flags.vertex_bad) begin
                     state_in = imdq_pkg::ST_ROOT;
                  end else begin
                     state_in = imdq_pkg::ST_DEC_MAP;
                  end
               end
               default: begin
                  state_in = imdq_pkg::ST_ROOT;
               end
            endcase
         end
         imdq_pkg::ST_EXT_SAVE: state_in = imdq_pkg::ST_EXT_TAKE;
         imdq_pkg::ST_EXT_TAKE: state_in = imdq_pkg::ST_SD_LEFT;
         imdq_pkg::ST_BLD_TAKE: state_in = imdq_pkg::ST_SD_LEFT;
         imdq_pkg::ST_SD_LEFT: begin
            if (flags.left_ok) begin
               state_in = imdq_pkg::ST_SD_RIGHT;
            end else if (sd_exit_extract) begin
               state_in = imdq_pkg::ST_EXT_PRUNE;
            end else begin
               state_in = imdq_pkg::ST_BLD_NEXT;
            end
         end
         imdq_pkg::ST_SD_RIGHT: state_in = imdq_pkg::ST_SD_STEP;
         imdq_pkg::ST_SD_STEP: begin
            if (flags.sd_move) begin
               state_in = imdq_pkg::ST_SD_LEFT;
            end else if (sd_exit_extract) begin
               state_in = imdq_pkg::ST_EXT_PRUNE;
            end else begin
               state_in = imdq_pkg::ST_BLD_NEXT;
            end
         end
         imdq_pkg::ST_EXT_PRUNE: state_in = imdq_pkg::ST_ROOT;
         imdq_pkg::ST_BLD_NEXT: begin
            if (flags.k_zero) begin
               state_in = imdq_pkg::ST_ROOT;
            end else begin
               state_in = imdq_pkg::ST_BLD_TAKE;
            end
         end
         imdq_pkg::ST_DEC_MAP: begin
            if (flags.map_bad) begin
               state_in = imdq_pkg::ST_ROOT;
            end else begin
               state_in = imdq_pkg::ST_DEC_SLOT;
            end
         end
         imdq_pkg::ST_DEC_SLOT: begin
            if (flags.slot_bad || flags.degree_zero) begin
               state_in = imdq_pkg::ST_ROOT;
            end else begin
               state_in = imdq_pkg::ST_SU_CHECK;
            end
         end
         imdq_pkg::ST_SU_CHECK: begin
            if (flags.hole_zero) begin
               state_in = imdq_pkg::ST_ROOT;
            end else begin
               state_in = imdq_pkg::ST_SU_STEP;
            end
         end
         imdq_pkg::ST_SU_STEP: begin
            if (flags.su_move) begin
               state_in = imdq_pkg::ST_SU_CHECK;
            end else begin
               state_in = imdq_pkg::ST_ROOT;
            end
         end
         imdq_pkg::ST_ROOT: state_in = imdq_pkg::ST_FINISH;
         imdq_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = imdq_pkg::ST_IDLE;
            end
         end
         default: state_in = imdq_pkg::ST_IDLE;
      endcase
   end

   // Datapath commands.
   always_comb begin
      cmd.op   = imdq_pkg::OP_NONE;
      cmd.code = imdq_pkg::STATUS_OK;
      unique case (state_ff)
         imdq_pkg::ST_CLEAR: cmd.op = imdq_pkg::OP_CLEAR;
         imdq_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.op = imdq_pkg::OP_CAPTURE;
            end
         end
         imdq_pkg::ST_DISPATCH: begin
            unique case (flags.func)
               imdq_pkg::FUNC_LOAD: begin
                  if (flags.vertex_bad) begin
                     cmd.op   = imdq_pkg::OP_FAIL;
                     cmd.code = imdq_pkg::STATUS_IGNORED;
                  end else if (flags.full) begin
                     cmd.op   = imdq_pkg::OP_FAIL;
                     cmd.code = imdq_pkg::STATUS_FULL;
                  end else begin
                     cmd.op = imdq_pkg::OP_LOAD;
                  end
               end
               imdq_pkg::FUNC_BUILD: begin
                  if (flags.empty) begin
                     cmd.op   = imdq_pkg::OP_FAIL;
                     cmd.code = imdq_pkg::STATUS_EMPTY;
                  end else if (!flags.single) begin
                     cmd.op = imdq_pkg::OP_BUILD_INIT;
                  end
               end
               imdq_pkg::FUNC_EXTRACT: begin
                  if (flags.empty) begin
                     cmd.op   = imdq_pkg::OP_FAIL;
                     cmd.code = imdq_pkg::STATUS_EMPTY;
                  end else begin
                     cmd.op = imdq_pkg::OP_EXT_READ_ROOT;
                  end
               end
               imdq_pkg::FUNC_DECREMENT: begin
                  if (flags.vertex_bad) begin
                     cmd.op   = imdq_pkg::OP_FAIL;
                     cmd.code = imdq_pkg::STATUS_IGNORED;
                  end else begin
                     cmd.op = imdq_pkg::OP_DEC_READ_MAP;
                  end
               end
               default: begin
               end
            endcase
         end
         imdq_pkg::ST_EXT_SAVE: cmd.op = imdq_pkg::OP_EXT_SAVE;
         imdq_pkg::ST_EXT_TAKE: cmd.op = imdq_pkg::OP_TAKE;
         imdq_pkg::ST_BLD_TAKE: cmd.op = imdq_pkg::OP_TAKE;
         imdq_pkg::ST_SD_LEFT: begin
            if (flags.left_ok) begin
               cmd.op = imdq_pkg::OP_SD_READ_LEFT;
            end else begin
               cmd.op = imdq_pkg::OP_PLACE;
            end
         end
         imdq_pkg::ST_SD_RIGHT: cmd.op = imdq_pkg::OP_SD_LEFT;
         imdq_pkg::ST_SD_STEP: begin
            if (flags.sd_move) begin
               cmd.op = imdq_pkg::OP_SD_STEP;
            end else begin
               cmd.op = imdq_pkg::OP_PLACE;
            end
         end
         imdq_pkg::ST_EXT_PRUNE: cmd.op = imdq_pkg::OP_PRUNE;
         imdq_pkg::ST_BLD_NEXT: begin
            if (!flags.k_zero) begin
               cmd.op = imdq_pkg::OP_BUILD_DEC;
            end
         end
         imdq_pkg::ST_DEC_MAP: begin
            if (flags.map_bad) begin
               cmd.op   = imdq_pkg::OP_FAIL;
               cmd.code = imdq_pkg::STATUS_IGNORED;
            end else begin
               cmd.op = imdq_pkg::OP_DEC_READ_SLOT;
            end
         end
         imdq_pkg::ST_DEC_SLOT: begin
            if (flags.slot_bad) begin
               cmd.op   = imdq_pkg::OP_FAIL;
               cmd.code = imdq_pkg::STATUS_IGNORED;
            end else if (flags.degree_zero) begin
               cmd.op   = imdq_pkg::OP_FAIL;
               cmd.code = imdq_pkg::STATUS_SATURATED;
            end else begin
               cmd.op = imdq_pkg::OP_DEC_TAKE;
            end
         end
         imdq_pkg::ST_SU_CHECK: begin
            if (flags.hole_zero) begin
               cmd.op = imdq_pkg::OP_PLACE;
            end else begin
               cmd.op = imdq_pkg::OP_SU_READ_PARENT;
            end
         end
         imdq_pkg::ST_SU_STEP: begin
            if (flags.su_move) begin
               cmd.op = imdq_pkg::OP_SU_STEP;
            end else begin
               cmd.op = imdq_pkg::OP_PLACE;
            end
         end
         imdq_pkg::ST_ROOT: cmd.op = imdq_pkg::OP_READ_ROOT;
         imdq_pkg::ST_FINISH: begin
            if (out_free) begin
               cmd.op = imdq_pkg::OP_FINISH;
            end
         end
         default: begin
         end
      endcase
   end

   // Result valid: set when a result is loaded, cleared when it is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == imdq_pkg::ST_FINISH && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= imdq_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != imdq_pkg::ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/imdq_checker.sv
// ----------------------------------------------------------------------------
// Indexed min-heap degree queue: port checker
// Observes the unit's ports and checks result consistency over time.
// ----------------------------------------------------------------------------
`include "indexed_min_heap_degree_queue_unit_macros.svh"

module imdq_checker #(
   parameter int MAX_VERTICES = 1024
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input imdq_pkg::rsp_type rsp_data
);

   // A stalled result item holds.
   `IMDQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // Once an item is taken the unit is busy in the next cycle.
   `IMDQ_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // An empty status always reports an empty heap.
   `IMDQ_ASSERT_SAME(a_empty_count, clock, reset, rsp_valid && rsp_data.status == imdq_pkg::STATUS_EMPTY, rsp_data.entry_count == 11'd0)

   // With nothing extracted and nothing left, the reported entry is zero.
   `IMDQ_ASSERT_SAME(a_empty_entry, clock, reset, rsp_valid && rsp_data.entry_count == 11'd0 && rsp_data.status != imdq_pkg::STATUS_OK, rsp_data.min_vertex == 10'd0 && rsp_data.min_degree == 10'd0)

   // The heap never reports more entries than it can hold.
   `IMDQ_ASSERT_SAME(a_count_bound, clock, reset, rsp_valid, 32'(rsp_data.entry_count) <= 32'(MAX_VERTICES))

endmodule

bind indexed_min_heap_degree_queue_unit imdq_checker #(
   .MAX_VERTICES (MAX_VERTICES)
) u_checker (.*);

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Indexed min-heap degree queue unit: self-checking testbench
// A table of directed items covers the empty, saturation and duplicate cases.
// Random episodes then load, build, extract and decrement. A last episode
// fills the heap to its limit. Results are checked against expected items.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH   = 1024;
   localparam int NO_SLOT = -1;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   imdq_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   imdq_pkg::rsp_type rsp_data;

   indexed_min_heap_degree_queue_unit #(.MAX_VERTICES(DEPTH)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // Predicted heap contents.
   logic [imdq_pkg::VERTEX_W-1:0] heap_vertex [DEPTH];
   logic [imdq_pkg::DEGREE_W-1:0] heap_degree [DEPTH];
   int                            slot_of [DEPTH];
   int                            heap_count;

   imdq_pkg::rsp_type pending_results [$];
   int      errors = 0;
   int      items_sent = 0;
   int      results_seen = 0;
   int      status_seen [5];
   int      tx_idle_pct = 38;
   int      rx_idle_pct = 71;

   // Exchanges two slots and repoints both vertices, first slot first.
   function automatic void swap_entries(int a, int b);
      logic [imdq_pkg::VERTEX_W-1:0] tv;
      logic [imdq_pkg::DEGREE_W-1:0] td;
      tv = heap_vertex[a];
      td = heap_degree[a];
      heap_vertex[a] = heap_vertex[b];
      heap_degree[a] = heap_degree[b];
      heap_vertex[b] = tv;
      heap_degree[b] = td;
      slot_of[heap_vertex[a]] = a;
      slot_of[heap_vertex[b]] = b;
   endfunction

   function automatic void push_down(int i);
      int l, r, m;
      forever begin
         l = 2 * i + 1;
         r = 2 * i + 2;
         m = i;
         if (l < heap_count && heap_degree[l] < heap_degree[m]) m = l;
         if (r < heap_count && heap_degree[r] < heap_degree[m]) m = r;
         if (m == i) return;
         swap_entries(i, m);
         i = m;
      end
   endfunction

   function automatic void push_up(int i);
      int p;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (heap_degree[p] <= heap_degree[i]) return;
         swap_entries(i, p);
         i = p;
      end
   endfunction

   // Applies one item to the predicted heap and returns the expected result.
   function automatic imdq_pkg::rsp_type heap_apply(imdq_pkg::req_type r);
      imdq_pkg::rsp_type o;
      int      pos, k;
      logic    taken;
      o = '0;
      o.status = imdq_pkg::STATUS_OK;
      taken = 1'b0;
      case (imdq_pkg::func_type'(r.func))
         imdq_pkg::FUNC_LOAD: begin
            if (heap_count >= DEPTH) o.status = imdq_pkg::STATUS_FULL;
            else begin
               heap_vertex[heap_count] = r.vertex;
               heap_degree[heap_count] = r.degree;
               slot_of[r.vertex] = heap_count;
               heap_count++;
            end
         end
         imdq_pkg::FUNC_BUILD: begin
            if (heap_count == 0) o.status = imdq_pkg::STATUS_EMPTY;
            else for (k = (heap_count - 2) / 2; k >= 0 && heap_count >= 2; k--)
               push_down(k);
         end
         imdq_pkg::FUNC_EXTRACT: begin
            if (heap_count == 0) o.status = imdq_pkg::STATUS_EMPTY;
            else begin
               o.min_vertex = heap_vertex[0];
               o.min_degree = heap_degree[0];
               taken = 1'b1;
               heap_vertex[0] = heap_vertex[heap_count-1];
               heap_degree[0] = heap_degree[heap_count-1];
               slot_of[heap_vertex[0]] = 0;
               heap_count--;
               push_down(0);
               slot_of[o.min_vertex] = NO_SLOT;
            end
         end
         default: begin
            pos = slot_of[r.vertex];
            if (pos == NO_SLOT || pos >= heap_count || heap_vertex[pos] != r.vertex)
               o.status = imdq_pkg::STATUS_IGNORED;
            else if (heap_degree[pos] == 0) o.status = imdq_pkg::STATUS_SATURATED;
            else begin
               heap_degree[pos] = heap_degree[pos] - 1'b1;
               push_up(pos);
            end
         end
      endcase
      if (!taken && heap_count > 0) begin
         o.min_vertex = heap_vertex[0];
         o.min_degree = heap_degree[0];
      end
      o.entry_count = imdq_pkg::COUNT_W'(heap_count);
      return o;
   endfunction

   // Offers one item, holding it until accepted; optionally a fixed result.
   task automatic send_item(imdq_pkg::req_type r, logic fixed,
                            imdq_pkg::rsp_type fixed_rsp);
      imdq_pkg::rsp_type predicted;
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      predicted = heap_apply(r);
      pending_results.push_back(fixed ? fixed_rsp : predicted);
      items_sent++;
      if (items_sent == 400) begin
         tx_idle_pct = 71;
         rx_idle_pct = 38;
      end else if (items_sent == 800) begin
         tx_idle_pct = 0;
         rx_idle_pct = 0;
      end
   endtask

   task automatic send_op(imdq_pkg::func_type f, int v, int d);
      imdq_pkg::req_type r;
      r.func   = f;
      r.vertex = imdq_pkg::VERTEX_W'(v);
      r.degree = imdq_pkg::DEGREE_W'(d);
      send_item(r, 1'b0, '0);
   endtask

   function automatic int pick_degree();
      return ($urandom_range(3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 1023);
   endfunction

   // A vertex still in the heap, or any vertex when the heap is empty.
   function automatic int pick_live();
      return (heap_count > 0) ? int'(heap_vertex[$urandom_range(0, heap_count - 1)])
                              : $urandom_range(0, 1023);
   endfunction

   // Load a handful, build, then peel: extract and decrement some neighbours.
   task automatic peel_episode();
      int n, k;
      n = $urandom_range(1, 30);
      repeat (n) begin
         if ($urandom_range(9) == 0)
            send_op(imdq_pkg::FUNC_LOAD, pick_live(), pick_degree());
         else send_op(imdq_pkg::FUNC_LOAD, $urandom_range(0, 1023), pick_degree());
         if ($urandom_range(14) == 0) send_op(imdq_pkg::FUNC_BUILD, 0, 0);
      end
      send_op(imdq_pkg::FUNC_BUILD, $urandom_range(0, 1023), $urandom_range(0, 1023));
      while (heap_count > 0) begin
         send_op(imdq_pkg::FUNC_EXTRACT, $urandom_range(0, 1023),
                 $urandom_range(0, 1023));
         k = $urandom_range(0, 4);
         repeat (k) begin
            if ($urandom_range(4) == 0)
               send_op(imdq_pkg::FUNC_DECREMENT, $urandom_range(0, 1023), 0);
            else send_op(imdq_pkg::FUNC_DECREMENT, pick_live(), $urandom_range(0, 1023));
         end
         if ($urandom_range(19) == 0)
            send_op(imdq_pkg::func_type'($urandom_range(0, 3)), $urandom_range(0, 1023),
                    $urandom_range(0, 1023));
         if ($urandom_range(14) == 0) begin
            send_op(imdq_pkg::FUNC_LOAD, $urandom_range(0, 1023), pick_degree());
            if ($urandom_range(1)) send_op(imdq_pkg::FUNC_BUILD, 0, 0);
         end
      end
      if ($urandom_range(2) == 0) send_op(imdq_pkg::FUNC_EXTRACT, 0, 0);
   endtask

   task automatic report_mismatch(string field, int got, int want);
      $display("MISMATCH result %0d %s: got %0d, expected %0d",
               results_seen, field, got, want);
      errors++;
   endtask

   // Result side: random stall and in-order comparison.
   always @(posedge clock) begin
      imdq_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected item", 1, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.min_vertex !== want.min_vertex)
               report_mismatch("min_vertex", rsp_data.min_vertex, want.min_vertex);
            if (rsp_data.min_degree !== want.min_degree)
               report_mismatch("min_degree", rsp_data.min_degree, want.min_degree);
            if (rsp_data.entry_count !== want.entry_count)
               report_mismatch("entry_count", rsp_data.entry_count, want.entry_count);
            if (rsp_data.status !== want.status)
               report_mismatch("status", rsp_data.status, want.status);
            if (want.status <= imdq_pkg::STATUS_SATURATED) status_seen[want.status]++;
         end
         results_seen++;
      end
      rsp_stall <= ($urandom_range(99) < rx_idle_pct);
   end

   // Directed rows: expected result typed in where it is obvious.
   typedef struct {
      imdq_pkg::req_type item;
      logic              fixed;
      imdq_pkg::rsp_type result;
   } row_type;

   row_type directed [] = '{
      '{'{imdq_pkg::FUNC_EXTRACT, 10'd0, 10'd0}, 1'b1,
        '{10'd0, 10'd0, 11'd0, imdq_pkg::STATUS_EMPTY}},
      '{'{imdq_pkg::FUNC_BUILD, 10'd1023, 10'd1023}, 1'b1,
        '{10'd0, 10'd0, 11'd0, imdq_pkg::STATUS_EMPTY}},
      '{'{imdq_pkg::FUNC_DECREMENT, 10'd5, 10'd0}, 1'b1,
        '{10'd0, 10'd0, 11'd0, imdq_pkg::STATUS_IGNORED}},
      '{'{imdq_pkg::FUNC_LOAD, 10'd1023, 10'd1023}, 1'b1,
        '{10'd1023, 10'd1023, 11'd1, imdq_pkg::STATUS_OK}},
      '{'{imdq_pkg::FUNC_BUILD, 10'd0, 10'd0}, 1'b1,
        '{10'd1023, 10'd1023, 11'd1, imdq_pkg::STATUS_OK}},
      '{'{imdq_pkg::FUNC_LOAD, 10'd0, 10'd0}, 1'b1,
        '{10'd1023, 10'd1023, 11'd2, imdq_pkg::STATUS_OK}},
      '{'{imdq_pkg::FUNC_BUILD, 10'd0, 10'd0}, 1'b1,
        '{10'd0, 10'd0, 11'd2, imdq_pkg::STATUS_OK}},
      '{'{imdq_pkg::FUNC_DECREMENT, 10'd0, 10'd0}, 1'b1,
        '{10'd0, 10'd0, 11'd2, imdq_pkg::STATUS_SATURATED}},
      '{'{imdq_pkg::FUNC_DECREMENT, 10'd1023, 10'd0}, 1'b1,
        '{10'd0, 10'd0, 11'd2, imdq_pkg::STATUS_OK}},
      '{'{imdq_pkg::FUNC_LOAD, 10'd0, 10'd5}, 1'b0, '0},
      '{'{imdq_pkg::FUNC_LOAD, 10'd512, 10'd1}, 1'b0, '0},
      '{'{imdq_pkg::FUNC_DECREMENT, 10'd0, 10'd0}, 1'b0, '0},
      '{'{imdq_pkg::FUNC_BUILD, 10'd0, 10'd0}, 1'b0, '0},
      '{'{imdq_pkg::FUNC_DECREMENT, 10'd512, 10'd0}, 1'b0, '0},
      '{'{imdq_pkg::FUNC_DECREMENT, 10'd512, 10'd0}, 1'b0, '0},
      '{'{imdq_pkg::FUNC_EXTRACT, 10'd0, 10'd0}, 1'b0, '0},
      '{'{imdq_pkg::FUNC_DECREMENT, 10'd0, 10'd0}, 1'b0, '0},
      '{'{imdq_pkg::FUNC_EXTRACT, 10'd0, 10'd0}, 1'b0, '0},
      '{'{imdq_pkg::FUNC_EXTRACT, 10'd0, 10'd0}, 1'b0, '0},
      '{'{imdq_pkg::FUNC_EXTRACT, 10'd0, 10'd0}, 1'b0, '0},
      '{'{imdq_pkg::FUNC_EXTRACT, 10'd0, 10'd0}, 1'b1,
        '{10'd0, 10'd0, 11'd0, imdq_pkg::STATUS_EMPTY}},
      '{'{imdq_pkg::FUNC_DECREMENT, 10'd1023, 10'd0}, 1'b1,
        '{10'd0, 10'd0, 11'd0, imdq_pkg::STATUS_IGNORED}}
   };

   // Main sequence.
   initial begin
      int waited;
      foreach (slot_of[i]) slot_of[i] = NO_SLOT;
      heap_count = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) send_item(directed[i].item, directed[i].fixed,
                                      directed[i].result);
      while (items_sent < 60) peel_episode();
      // Fill to the limit, overflow twice, then peel a little.
      while (heap_count < DEPTH)
         send_op(imdq_pkg::FUNC_LOAD, $urandom_range(0, 1023), pick_degree());
      send_op(imdq_pkg::FUNC_LOAD, 7, 7);
      send_op(imdq_pkg::FUNC_LOAD, 1023, 0);
      send_op(imdq_pkg::FUNC_BUILD, 0, 0);
      repeat (12) begin
         send_op(imdq_pkg::FUNC_EXTRACT, 0, 0);
         repeat (3) send_op(imdq_pkg::FUNC_DECREMENT, pick_live(), 0);
      end
      req_valid <= 1'b0;
      waited = 0;
      while (pending_results.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (60) @(posedge clock);
      $display("Sent %0d items, checked %0d results, %0d mismatches.",
               items_sent, results_seen, errors);
      $display("Status counts ok/empty/full/ignored/saturated: %0d/%0d/%0d/%0d/%0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               status_seen[4]);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #30ms;
      $display("Some tests failed");
      $finish;
   end

endmodule

>>> indexed_min_heap_degree_queue_unit.f
+incdir+rtl
rtl/imdq_pkg.sv
rtl/imdq_datapath.sv
rtl/imdq_ctrl.sv
rtl/indexed_min_heap_degree_queue_unit.sv
rtl/imdq_checker.sv
tb/tb_top.sv
